// ===== sv/cmps_pkg.sv =====
package cmps_pkg;

    localparam int MEM_DEPTH   = 65536;  // power of two, 256 .. 65536
    localparam int MAX_PATTERN = 64;     // 1 .. 64

    localparam int ADDR_W  = $clog2(MEM_DEPTH);
    localparam int PADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int OFF_W   = $clog2(MAX_PATTERN + 1);
    localparam int CNT_W   = ADDR_W + 1;

    // fixed port widths
    localparam int PORT_ADDR_W = 16;
    localparam int PORT_PIDX_W = 6;
    localparam int PORT_LEN_W  = 7;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [PADDR_W-1:0] t_paddr;
    typedef logic [OFF_W-1:0]   t_off;

    typedef enum logic [1:0] {
        KIND_MEM_WR = 2'd0,
        KIND_PAT_WR = 2'd1,
        KIND_SEARCH = 2'd2
    } t_kind;

    typedef struct packed {
        t_addr  mem_addr;
        t_paddr pat_addr;
    } t_rd_req;

    // one step of the candidate position, wrapping at the memory size
    function automatic t_addr step_pos(input t_addr p, input logic down);
        t_addr r;
        if (down) begin
            r = (p == '0) ? ADDR_W'(MEM_DEPTH - 1) : p - 1'b1;
        end else begin
            r = (p == ADDR_W'(MEM_DEPTH - 1)) ? '0 : p + 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== sv/cmps_ram.sv =====
module cmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/cmps_seq.sv =====
module cmps_seq (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_go,
    input  logic [cmps_pkg::PORT_ADDR_W-1:0] i_start_position,
    input  logic                             i_backward,
    input  logic [cmps_pkg::PORT_LEN_W-1:0]  i_pattern_length,
    input  logic [7:0]                       i_mem_rdata,
    input  logic [7:0]                       i_pat_rdata,
    output cmps_pkg::t_rd_req                o_rd,
    output logic                             o_busy,
    output logic                             o_valid,
    output logic                             o_found,
    output logic [cmps_pkg::PORT_ADDR_W-1:0] o_match_position,
    output logic [cmps_pkg::PORT_LEN_W-1:0]  o_match_length
);

    typedef enum logic {ST_IDLE, ST_SCAN} t_state;

    t_state                       r_state, n_state;
    cmps_pkg::t_addr              r_pos, n_pos;
    cmps_pkg::t_addr              r_maddr, n_maddr;
    cmps_pkg::t_off               r_off, n_off;
    cmps_pkg::t_off               r_len, n_len;
    logic [cmps_pkg::CNT_W-1:0]   r_count, n_count;
    logic                         r_down, n_down;
    logic                         r_pend, n_pend;
    logic                         r_last, n_last;
    logic                         r_valid, n_valid;
    logic                         r_found, n_found;
    cmps_pkg::t_addr              r_mpos, n_mpos;
    cmps_pkg::t_off               r_mlen, n_mlen;

    cmps_pkg::t_off  len_sat;
    cmps_pkg::t_addr first_pos;
    cmps_pkg::t_addr next_pos;
    logic            issue;
    logic            mismatch;

    assign len_sat = (32'(i_pattern_length) > cmps_pkg::MAX_PATTERN)
                   ? cmps_pkg::OFF_W'(cmps_pkg::MAX_PATTERN)
                   : cmps_pkg::OFF_W'(i_pattern_length);
    assign first_pos = cmps_pkg::step_pos(i_start_position[cmps_pkg::ADDR_W-1:0], i_backward);
    assign next_pos  = cmps_pkg::step_pos(r_pos, r_down);
    assign issue     = (r_off < r_len);
    assign mismatch  = r_pend && (i_mem_rdata != i_pat_rdata);

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_maddr = r_maddr;
        n_off   = r_off;
        n_len   = r_len;
        n_count = r_count;
        n_down  = r_down;
        n_pend  = r_pend;
        n_last  = r_last;
        n_valid = 1'b0;
        n_found = r_found;
        n_mpos  = r_mpos;
        n_mlen  = r_mlen;
        case (r_state)
            ST_IDLE: begin
                n_pend = 1'b0;
                if (i_go) begin
                    if (len_sat == '0) begin
                        // empty pattern hits the first candidate
                        n_valid = 1'b1;
                        n_found = 1'b1;
                        n_mpos  = first_pos;
                        n_mlen  = '0;
                    end else begin
                        n_state = ST_SCAN;
                        n_pos   = first_pos;
                        n_maddr = first_pos;
                        n_off   = '0;
                        n_len   = len_sat;
                        n_count = cmps_pkg::CNT_W'(1);
                        n_down  = i_backward;
                    end
                end
            end
            ST_SCAN: begin
                if (mismatch) begin
                    n_pend = 1'b0;
                    if (r_count == cmps_pkg::CNT_W'(cmps_pkg::MEM_DEPTH)) begin
                        n_state = ST_IDLE;
                        n_valid = 1'b1;
                        n_found = 1'b0;
                        n_mpos  = '0;
                        n_mlen  = '0;
                    end else begin
                        n_pos   = next_pos;
                        n_maddr = next_pos;
                        n_off   = '0;
                        n_count = r_count + 1'b1;
                    end
                end else if (r_pend && r_last) begin
                    n_state = ST_IDLE;
                    n_pend  = 1'b0;
                    n_valid = 1'b1;
                    n_found = 1'b1;
                    n_mpos  = r_pos;
                    n_mlen  = r_len;
                end else begin
                    // read in flight for this offset, compared next cycle
                    n_pend = issue;
                    n_last = (r_off + 1'b1 == r_len);
                    if (issue) begin
                        n_off   = r_off + 1'b1;
                        n_maddr = cmps_pkg::step_pos(r_maddr, 1'b0);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
        r_pos   <= n_pos;
        r_maddr <= n_maddr;
        r_off   <= n_off;
        r_len   <= n_len;
        r_count <= n_count;
        r_down  <= n_down;
        r_last  <= n_last;
        r_found <= n_found;
        r_mpos  <= n_mpos;
        r_mlen  <= n_mlen;
    end

    assign o_rd.mem_addr    = r_maddr;
    assign o_rd.pat_addr    = r_off[cmps_pkg::PADDR_W-1:0];
    assign o_busy           = (r_state != ST_IDLE);
    assign o_valid          = r_valid;
    assign o_found          = r_found;
    assign o_match_position = cmps_pkg::PORT_ADDR_W'(r_mpos);
    assign o_match_length   = cmps_pkg::PORT_LEN_W'(r_mlen);

endmodule

// ===== sv/circular_memory_pattern_search_unit.sv =====
// Write items (memory or pattern byte) are taken while idle; busy stays low.
// Search: empty pattern reports in the cycle after start. Otherwise candidates are
// compared one byte per cycle through the memory read port; a scan without a match
// ends once every position has been tried as a candidate.
// Result is strobed by o_valid for one cycle; the receiver cannot stall it.
// Synchronous active-low reset clears control only; memory contents are kept.
module circular_memory_pattern_search_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_kind,
    input  logic [cmps_pkg::PORT_ADDR_W-1:0] i_address,
    input  logic [cmps_pkg::PORT_PIDX_W-1:0] i_pattern_index,
    input  logic [7:0]                       i_byte_value,
    input  logic [cmps_pkg::PORT_LEN_W-1:0]  i_pattern_length,
    input  logic [cmps_pkg::PORT_ADDR_W-1:0] i_start_position,
    input  logic                             i_backward,
    output logic                             o_valid,
    output logic                             o_found,
    output logic [cmps_pkg::PORT_ADDR_W-1:0] o_match_position,
    output logic [cmps_pkg::PORT_LEN_W-1:0]  o_match_length
);

    logic              accept;
    logic              mem_we;
    logic              pat_we;
    logic              go;
    logic [7:0]        mem_rdata;
    logic [7:0]        pat_rdata;
    cmps_pkg::t_rd_req rd;

    assign accept = start && !busy;
    assign mem_we = accept && (i_kind == cmps_pkg::KIND_MEM_WR);
    assign pat_we = accept && (i_kind == cmps_pkg::KIND_PAT_WR)
                  && (32'(i_pattern_index) < cmps_pkg::MAX_PATTERN);
    assign go     = accept && (i_kind == cmps_pkg::KIND_SEARCH);

    cmps_ram #(
        .WIDTH (8),
        .DEPTH (cmps_pkg::MEM_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (i_address[cmps_pkg::ADDR_W-1:0]),
        .i_wdata (i_byte_value),
        .i_raddr (rd.mem_addr),
        .o_rdata (mem_rdata)
    );

    cmps_ram #(
        .WIDTH (8),
        .DEPTH (2 ** cmps_pkg::PADDR_W)
    ) u_pat (
        .i_clk   (i_clk),
        .i_we    (pat_we),
        .i_waddr (cmps_pkg::PADDR_W'(i_pattern_index)),
        .i_wdata (i_byte_value),
        .i_raddr (rd.pat_addr),
        .o_rdata (pat_rdata)
    );

    cmps_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_go             (go),
        .i_start_position (i_start_position),
        .i_backward       (i_backward),
        .i_pattern_length (i_pattern_length),
        .i_mem_rdata      (mem_rdata),
        .i_pat_rdata      (pat_rdata),
        .o_rd             (rd),
        .o_busy           (busy),
        .o_valid          (o_valid),
        .o_found          (o_found),
        .o_match_position (o_match_position),
        .o_match_length   (o_match_length)
    );

endmodule

// ===== tb/sv/circular_memory_pattern_search_unit_test.sv =====
module circular_memory_pattern_search_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // never placed in the bulk fill, so a search for it scans every position
    localparam logic [7:0] ABSENT_BYTE = 8'hA5;
    localparam int CYCLE_LIMIT = 5_000_000;

    typedef struct packed {
        logic                             found;
        logic [cmps_pkg::PORT_ADDR_W-1:0] position;
        logic [cmps_pkg::PORT_LEN_W-1:0]  length;
    } t_search_outcome;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             busy;
    logic [1:0]                       i_kind = '0;
    logic [cmps_pkg::PORT_ADDR_W-1:0] i_address = '0;
    logic [cmps_pkg::PORT_PIDX_W-1:0] i_pattern_index = '0;
    logic [7:0]                       i_byte_value = '0;
    logic [cmps_pkg::PORT_LEN_W-1:0]  i_pattern_length = '0;
    logic [cmps_pkg::PORT_ADDR_W-1:0] i_start_position = '0;
    logic                             i_backward = 1'b0;
    logic                             o_valid;
    logic                             o_found;
    logic [cmps_pkg::PORT_ADDR_W-1:0] o_match_position;
    logic [cmps_pkg::PORT_LEN_W-1:0]  o_match_length;

    logic [7:0]      mem_image [cmps_pkg::MEM_DEPTH];
    logic [7:0]      pat_image [cmps_pkg::MAX_PATTERN];
    t_search_outcome pending_results [$];
    t_search_outcome head_result;
    int              err_count = 0;
    int              cycle_count = 0;
    bit              gaps_on = 1'b1;

    circular_memory_pattern_search_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_address        (i_address),
        .i_pattern_index  (i_pattern_index),
        .i_byte_value     (i_byte_value),
        .i_pattern_length (i_pattern_length),
        .i_start_position (i_start_position),
        .i_backward       (i_backward),
        .o_valid          (o_valid),
        .o_found          (o_found),
        .o_match_position (o_match_position),
        .o_match_length   (o_match_length)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("circular_memory_pattern_search_unit: mismatch");
            $finish;
        end
    end

    // first candidate is one step away from the start position, start itself is last
    function automatic t_search_outcome predict_search(input logic [15:0] from,
                                                       input logic [6:0] len,
                                                       input logic back);
        t_search_outcome r;
        int              n_bytes;
        cmps_pkg::t_addr cand;
        bit              hit;
        r = '0;
        n_bytes = (len > cmps_pkg::MAX_PATTERN) ? cmps_pkg::MAX_PATTERN : len;
        cand = cmps_pkg::t_addr'(from);
        for (int n = 0; n < cmps_pkg::MEM_DEPTH; n++) begin
            cand = back ? cand - 1'b1 : cand + 1'b1;
            hit = 1'b1;
            for (int i = 0; i < n_bytes && hit; i++) begin
                if (pat_image[i] != mem_image[cmps_pkg::t_addr'(cand + i)]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                r.found = 1'b1;
                r.position = cand;
                r.length = 7'(n_bytes);
                return r;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result with no search pending: found %0b position %0h length %0d",
                       o_found, o_match_position, o_match_length);
                err_count++;
            end else begin
                head_result = pending_results.pop_front();
                if (o_found !== head_result.found) begin
                    $error("found: expected %0b, got %0b", head_result.found, o_found);
                    err_count++;
                end
                if (o_match_position !== head_result.position) begin
                    $error("match_position: expected %0h, got %0h",
                           head_result.position, o_match_position);
                    err_count++;
                end
                if (o_match_length !== head_result.length) begin
                    $error("match_length: expected %0d, got %0d",
                           head_result.length, o_match_length);
                    err_count++;
                end
            end
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic [15:0] addr,
                             input logic [5:0] pidx, input logic [7:0] val,
                             input logic [6:0] len, input logic [15:0] from,
                             input logic back);
        int gap;
        gap = (gaps_on && $urandom_range(99) < 15) ? 1 : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_kind <= kind;
        i_address <= addr;
        i_pattern_index <= pidx;
        i_byte_value <= val;
        i_pattern_length <= len;
        i_start_position <= from;
        i_backward <= back;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        case (kind)
            cmps_pkg::KIND_MEM_WR: mem_image[addr] = val;
            cmps_pkg::KIND_PAT_WR: pat_image[pidx] = val;
            cmps_pkg::KIND_SEARCH: pending_results.insert(pending_results.size(),
                                                          predict_search(from, len, back));
            default: ;
        endcase
    endtask

    task automatic write_mem(input logic [15:0] addr, input logic [7:0] val);
        send_item(cmps_pkg::KIND_MEM_WR, addr, 6'($urandom), val, 7'($urandom),
                  16'($urandom), 1'($urandom));
    endtask

    task automatic write_pat(input logic [5:0] pidx, input logic [7:0] val);
        send_item(cmps_pkg::KIND_PAT_WR, 16'($urandom), pidx, val, 7'($urandom),
                  16'($urandom), 1'($urandom));
    endtask

    task automatic search(input logic [15:0] from, input logic [6:0] len, input logic back);
        send_item(cmps_pkg::KIND_SEARCH, 16'($urandom), 6'($urandom), 8'($urandom), len,
                  from, back);
    endtask

    task automatic copy_pattern(input logic [15:0] base, input int n_bytes);
        for (int i = 0; i < n_bytes; i++) begin
            write_pat(6'(i), mem_image[16'(base + i)]);
        end
    endtask

    // start must drop before the wait, or the last item would be taken again
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_reset();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // mostly a 4-letter alphabet so copied patterns are found within a short scan
    task automatic load_memory();
        logic [7:0] v;
        for (int a = 0; a < cmps_pkg::MEM_DEPTH; a++) begin
            gaps_on = !(a >= 20000 && a < 36000);
            if ($urandom_range(15) == 0) begin
                v = 8'($urandom_range(4, 255));
                if (v == ABSENT_BYTE) v = 8'h5A;
            end else begin
                v = 8'($urandom_range(3));
            end
            write_mem(16'(a), v);
        end
        gaps_on = 1'b1;
    endtask

    task automatic load_pattern();
        for (int i = 0; i < cmps_pkg::MAX_PATTERN; i++) begin
            write_pat(6'(i), 8'($urandom));
        end
    endtask

    task automatic test_empty_pattern();
        search(16'hFFFF, 7'd0, 1'b0);
        search(16'h0000, 7'd0, 1'b1);
        search(16'($urandom), 7'd0, 1'($urandom));
        wait_drained();
    endtask

    task automatic test_wrap_compare();
        write_mem(16'hFFFE, 8'hF1);
        write_mem(16'hFFFF, 8'hF2);
        write_mem(16'h0000, 8'hF3);
        write_mem(16'h0001, 8'hF4);
        copy_pattern(16'hFFFE, 4);
        search(16'hFF00, 7'd4, 1'b0);
        search(16'h0100, 7'd4, 1'b1);
        wait_drained();
    endtask

    task automatic test_long_pattern();
        logic [15:0] base;
        base = 16'h4000 + 16'($urandom_range(4095));
        copy_pattern(base, cmps_pkg::MAX_PATTERN);
        search(base - 16'd300, 7'd64, 1'b0);
        search(base + 16'd200, 7'd127, 1'b1);
        search(base - 16'd5, 7'd65, 1'b0);
        wait_drained();
    endtask

    task automatic test_unknown_kind();
        repeat (3) begin
            send_item(KIND_UNUSED, 16'($urandom), 6'($urandom), 8'($urandom), 7'($urandom),
                      16'($urandom), 1'($urandom));
        end
        search(16'($urandom), 7'd0, 1'($urandom));
        wait_drained();
    endtask

    task automatic test_no_match();
        write_pat(6'd0, ABSENT_BYTE);
        wait_drained();
        search(16'($urandom), 7'd1, 1'b1);
        wait_drained();
    endtask

    task automatic test_start_last();
        logic [15:0] spot;
        spot = 16'($urandom);
        write_mem(spot, ABSENT_BYTE);
        search(spot, 7'd1, 1'b0);
        wait_drained();
        write_mem(spot, 8'($urandom_range(3)));
    endtask

    task automatic test_random_search();
        int          n_bytes;
        int          span;
        int          sel;
        logic [6:0]  len;
        logic [15:0] from;
        logic [15:0] target;
        logic        back;
        for (int ep = 0; ep < 40; ep++) begin
            gaps_on = !(ep >= 12 && ep < 22);
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 3)) write_mem(16'($urandom), 8'($urandom));
            end
            if ($urandom_range(4) == 0) begin
                send_item(KIND_UNUSED, 16'($urandom), 6'($urandom), 8'($urandom),
                          7'($urandom), 16'($urandom), 1'($urandom));
            end
            sel = $urandom_range(9);
            case (sel)
                0: len = 7'd0;
                7: len = 7'($urandom_range(9, 63));
                8: len = 7'd64;
                9: len = 7'($urandom_range(65, 127));
                default: len = 7'($urandom_range(1, 8));
            endcase
            back = 1'($urandom);
            span = $urandom_range(1, 3000);
            from = 16'($urandom);
            target = back ? from - 16'(span) : from + 16'(span);
            if ($urandom_range(7) == 0) begin
                // pattern not taken from memory; kept short so a hit stays likely
                len = 7'($urandom_range(1, 3));
                for (int i = 0; i < len; i++) write_pat(6'(i), 8'($urandom_range(3)));
            end else begin
                n_bytes = (len > cmps_pkg::MAX_PATTERN) ? cmps_pkg::MAX_PATTERN : len;
                copy_pattern(target, n_bytes);
            end
            n_bytes = (len > cmps_pkg::MAX_PATTERN) ? cmps_pkg::MAX_PATTERN : len;
            if (n_bytes < cmps_pkg::MAX_PATTERN && $urandom_range(3) == 0) begin
                write_pat(6'($urandom_range(n_bytes, cmps_pkg::MAX_PATTERN - 1)),
                          8'($urandom));
            end
            search(from, len, back);
            if ($urandom_range(7) == 0) wait_drained();
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        run_reset();
        load_memory();
        load_pattern();
        test_empty_pattern();
        test_wrap_compare();
        test_long_pattern();
        test_unknown_kind();
        test_no_match();
        test_start_last();
        test_random_search();
        wait_drained();
        repeat (16) @(posedge i_clk);
        if (err_count == 0) begin
            $display("circular_memory_pattern_search_unit: match");
        end else begin
            $display("circular_memory_pattern_search_unit: mismatch");
        end
        $finish;
    end

endmodule
